// ----- rtl/sstl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sstl_pkg - shared types and constants for the threading leadscrew block
// Fixed-point widths, register indexes, controller states and the command
// bundle that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package sstl_pkg;

	// Fraction bits of the turn position.
	localparam int FRAC_BITS = 16;

	// Long division of |count| << FRAC_BITS by pulses per rev, one bit a cycle.
	localparam int DIV_STEPS = 32 + FRAC_BITS;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	// Turn position in turns, signed, FRAC_BITS fraction bits.
	localparam int X_W      = 34 + FRAC_BITS;
	localparam int MAG_HI_W = X_W - 32;
	localparam int PROD_W   = X_W + 32;
	localparam int SHIFT    = FRAC_BITS + 16;
	localparam int R_W      = PROD_W - SHIFT;

	// Register reset values.
	localparam logic [15:0] PPR_RESET = 16'd2880;
	localparam logic [31:0] SPR_RESET = 32'd52428800;

	typedef enum logic [2:0] {
		REG_PULSES_PER_REV    = 3'd0,
		REG_STEPS_PER_REV     = 3'd1,
		REG_START_OFFSET      = 3'd2,
		REG_LEFT_LIMIT        = 3'd3,
		REG_RIGHT_LIMIT       = 3'd4,
		REG_LEFT_STOP_ENABLE  = 3'd5,
		REG_RIGHT_STOP_ENABLE = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic        [15:0] pulses_per_rev;
		logic        [31:0] steps_per_rev_q16;
		logic        [15:0] start_offset_q16;
		logic signed [31:0] left_limit;
		logic signed [31:0] right_limit;
		logic               left_stop_enable;
		logic               right_stop_enable;
	} sstl_cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_PREP,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_SCALE,
		ST_MOVE,
		ST_ARM
	} sstl_state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic prep;
		logic mul_lo;
		logic mul_hi;
		logic scale;
		logic move;
		logic arm;
	} sstl_cmd_t;

endpackage
`default_nettype wire

// ----- rtl/spindle_synced_thread_leadscrew_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spindle_synced_thread_leadscrew_top - spindle-synchronized threading
// Turn spindle counts into leadscrew step targets; arm and disarm threading.
// Input channel (in_valid / in_stall): one item per control tick carrying
// the spindle count, carriage position and switch and button levels.
// Output channel (out_valid / out_stall): exactly one result per item with
// move_valid, target_pos and thread_active.
// Configuration: cfg_we writes cfg_data into register cfg_index; write only
// while no item is in flight.
// Each item runs the one-bit-per-cycle division by pulses per rev; an armed
// item then adds the turn sum, two multiplier partial products and
// saturation. One item at a time: in_stall is high while an item is at work.
// A held result sits in the output register; the next item is taken while it
// waits. If out_stall is still high when the next result is ready, the block
// holds that result and the threading state until the transfer frees a slot.
// Reset clears the threading state and output valid flag and loads the
// register defaults (2880 pulses per rev, 800 steps per rev).
// ----------------------------------------------------------------------------
module spindle_synced_thread_leadscrew_top
	import sstl_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration write port
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	// input channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [31:0] spindle_count,
	input  wire logic signed [31:0] carriage_pos,
	input  wire logic               jog_switch_level,
	input  wire logic               left_button_level,
	input  wire logic               right_button_level,
	// output channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    move_valid,
	output logic signed [31:0]      target_pos,
	output logic                    thread_active
);

	sstl_cfg_t cfg;
	sstl_cmd_t cmd;
	logic      armed;

	// Registers: user keeps values fixed while an item is in flight; not enforced
	sstl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Controller: one item at a time, result released when the output frees
	sstl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.armed     (armed),
		.cmd       (cmd)
	);

	// Datapath: divider, scaling, target selection and output register
	sstl_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.cfg                (cfg),
		.spindle_count      (spindle_count),
		.carriage_pos       (carriage_pos),
		.jog_switch_level   (jog_switch_level),
		.left_button_level  (left_button_level),
		.right_button_level (right_button_level),
		.armed              (armed),
		.move_valid         (move_valid),
		.target_pos         (target_pos),
		.thread_active      (thread_active)
	);

endmodule
`default_nettype wire

// ----- rtl/sstl_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sstl_cfg - configuration register file
// Write-only registers loaded through a plain indexed write port.
// ----------------------------------------------------------------------------
module sstl_cfg
	import sstl_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	output sstl_cfg_t        cfg
);

	sstl_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulses_per_rev    <= PPR_RESET;
			cfg_q.steps_per_rev_q16 <= SPR_RESET;
			cfg_q.start_offset_q16  <= '0;
			cfg_q.left_limit        <= '0;
			cfg_q.right_limit       <= '0;
			cfg_q.left_stop_enable  <= 1'b0;
			cfg_q.right_stop_enable <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PULSES_PER_REV:    cfg_q.pulses_per_rev    <= cfg_data[15:0];
				REG_STEPS_PER_REV:     cfg_q.steps_per_rev_q16 <= cfg_data;
				REG_START_OFFSET:      cfg_q.start_offset_q16  <= cfg_data[15:0];
				REG_LEFT_LIMIT:        cfg_q.left_limit        <= $signed(cfg_data);
				REG_RIGHT_LIMIT:       cfg_q.right_limit       <= $signed(cfg_data);
				REG_LEFT_STOP_ENABLE:  cfg_q.left_stop_enable  <= cfg_data[0];
				REG_RIGHT_STOP_ENABLE: cfg_q.right_stop_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ----- rtl/sstl_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sstl_ctrl - sequencing controller
// Steps one item through division, scaling when armed and the final update,
// and owns the input stall and the output valid flag.
// ----------------------------------------------------------------------------
module sstl_ctrl
	import sstl_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  wire logic out_stall,
	input  wire logic armed,
	output sstl_cmd_t cmd
);

	sstl_state_t state_q, state_nxt;
	logic [CNT_W-1:0] cnt_q;
	logic out_valid_q;
	logic out_free;
	logic div_last;

	assign out_free = !out_valid_q || !out_stall;
	assign div_last = (cnt_q == CNT_W'(DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (div_last) begin
					state_nxt = armed ? ST_PREP : ST_ARM;
				end
			end
			ST_PREP: begin
				cmd.prep  = 1'b1;
				state_nxt = ST_MUL_LO;
			end
			ST_MUL_LO: begin
				cmd.mul_lo = 1'b1;
				state_nxt  = ST_MUL_HI;
			end
			ST_MUL_HI: begin
				cmd.mul_hi = 1'b1;
				state_nxt  = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_nxt = ST_MOVE;
			end
			ST_MOVE: begin
				if (out_free) begin
					cmd.move  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			ST_ARM: begin
				if (out_free) begin
					cmd.arm   = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Division step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == ST_DIV && !div_last) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else begin
			cnt_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.move || cmd.arm) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ----- rtl/sstl_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sstl_dp - threading datapath
// Bit-serial divider, turn position, split multiplier, target and arming
// logic, threading state and the output register.
// ----------------------------------------------------------------------------
module sstl_dp
	import sstl_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sstl_cmd_t          cmd,
	input  wire sstl_cfg_t          cfg,
	input  wire logic signed [31:0] spindle_count,
	input  wire logic signed [31:0] carriage_pos,
	input  wire logic               jog_switch_level,
	input  wire logic               left_button_level,
	input  wire logic               right_button_level,
	output logic                    armed,
	output logic                    move_valid,
	output logic signed [31:0]      target_pos,
	output logic                    thread_active
);

	// Latched item
	logic               count_neg_q;
	logic signed [31:0] pos_q;
	logic               jog_q;
	logic               lup_q;
	logic               rup_q;

	// Divider
	logic [DIV_STEPS-1:0] quot_q;
	logic [15:0]          rem_q;

	// Scaling
	logic                     xneg_q;
	logic [X_W-1:0]           xmag_q;
	logic [63:0]              pp0_q;
	logic [X_W-1:0]           pp1_q;
	logic signed [32:0]       steps_q;

	// Threading state
	logic               active_q;
	logic               going_right_q;
	logic signed [31:0] turn_origin_q;
	logic signed [31:0] pos_origin_q;

	// Output register
	logic               move_valid_q;
	logic signed [31:0] target_pos_q;
	logic               thread_active_q;

	// ---------------- division ----------------
	logic [15:0] ppr_eff;
	logic [31:0] count_mag;
	logic [16:0] trial;
	logic        trial_ge;
	logic [15:0] rem_nxt;

	assign ppr_eff   = (cfg.pulses_per_rev == '0) ? 16'd1 : cfg.pulses_per_rev;
	assign count_mag = spindle_count[31] ? 32'(-spindle_count) : spindle_count;
	assign trial     = {rem_q, quot_q[DIV_STEPS-1]};
	assign trial_ge  = (trial >= {1'b0, ppr_eff});
	assign rem_nxt   = trial_ge ? 16'(trial - {1'b0, ppr_eff}) : trial[15:0];

	// ---------------- turn position ----------------
	logic [31:0]              q_turn;
	logic [FRAC_BITS-1:0]     q_frac;
	logic signed [31:0]       turns;
	logic signed [FRAC_BITS:0] frac;
	logic [15+FRAC_BITS:0]    off_wide;
	logic [FRAC_BITS-1:0]     off;
	logic signed [32:0]       elapsed;
	logic signed [X_W-1:0]    x;

	assign q_turn   = quot_q[DIV_STEPS-1:FRAC_BITS];
	assign q_frac   = quot_q[FRAC_BITS-1:0];
	assign turns    = count_neg_q ? -$signed(q_turn) : $signed(q_turn);
	assign frac     = count_neg_q ? -$signed({1'b0, q_frac}) : $signed({1'b0, q_frac});
	assign off_wide = {cfg.start_offset_q16, {FRAC_BITS{1'b0}}};
	assign off      = off_wide[15+FRAC_BITS:16];
	assign elapsed  = $signed({turns[31], turns}) - $signed({turn_origin_q[31], turn_origin_q});
	assign x = $signed({{(X_W-33-FRAC_BITS){elapsed[32]}}, elapsed, {FRAC_BITS{1'b0}}})
		+ $signed({{(X_W-FRAC_BITS-1){frac[FRAC_BITS]}}, frac})
		+ $signed({{(X_W-FRAC_BITS){1'b0}}, off});

	// ---------------- scaling ----------------
	logic [PROD_W-1:0]  prod;
	logic [R_W-1:0]     r;
	logic [32:0]        neg_mag;
	logic signed [32:0] steps_nxt;

	assign prod = {{(PROD_W-64){1'b0}}, pp0_q} + {pp1_q, 32'b0};
	assign r    = prod[PROD_W-1:SHIFT];

	always_comb begin
		neg_mag = (r > R_W'(33'h0_8000_0000)) ? 33'h0_8000_0000 : r[32:0];
		if (xneg_q) begin
			steps_nxt = -$signed(neg_mag);
		end else if (r > R_W'(32'h7FFF_FFFF)) begin
			steps_nxt = 33'sh0_7FFF_FFFF;
		end else begin
			steps_nxt = $signed({1'b0, r[31:0]});
		end
	end

	// ---------------- target and disarm ----------------
	logic signed [33:0] org34;
	logic signed [33:0] st34;
	logic signed [33:0] sum34;
	logic signed [31:0] sat_t;
	logic signed [31:0] move_t;
	logic               move_active;

	assign org34 = {{2{pos_origin_q[31]}}, pos_origin_q};
	assign st34  = {steps_q[32], steps_q};
	assign sum34 = going_right_q ? (org34 - st34) : (org34 + st34);

	always_comb begin
		if (sum34[33:31] == 3'b000 || sum34[33:31] == 3'b111) begin
			sat_t = sum34[31:0];
		end else if (sum34[33]) begin
			sat_t = 32'sh8000_0000;
		end else begin
			sat_t = 32'sh7FFF_FFFF;
		end

		move_t      = sat_t;
		move_active = 1'b1;
		if (going_right_q) begin
			// hold the target at or right of the origin
			if (sat_t < pos_origin_q) begin
				move_t = pos_origin_q;
			end
			if (jog_q) begin
				if (rup_q) begin
					move_active = 1'b0;
				end
			end else if (move_t >= cfg.right_limit) begin
				move_active = 1'b0;
				move_t      = cfg.right_limit;
			end
		end else begin
			if (sat_t > pos_origin_q) begin
				move_t = pos_origin_q;
			end
			if (jog_q) begin
				if (lup_q) begin
					move_active = 1'b0;
				end
			end else if (move_t <= cfg.left_limit) begin
				move_active = 1'b0;
				move_t      = cfg.left_limit;
			end
		end
		if (jog_q && lup_q && rup_q) begin
			move_active = 1'b0;
		end
	end

	// ---------------- arming ----------------
	logic arm_l;
	logic arm_r;

	assign arm_l = jog_q ? !lup_q
		: (!lup_q && cfg.left_stop_enable && (pos_q > cfg.left_limit));
	assign arm_r = jog_q ? !rup_q
		: (!rup_q && cfg.right_stop_enable && (pos_q < cfg.right_limit));

	// ---------------- registers ----------------
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			count_neg_q <= spindle_count[31];
			pos_q       <= carriage_pos;
			jog_q       <= jog_switch_level;
			lup_q       <= left_button_level;
			rup_q       <= right_button_level;
			quot_q      <= {count_mag, {FRAC_BITS{1'b0}}};
			rem_q       <= '0;
		end else if (cmd.div_step) begin
			quot_q <= {quot_q[DIV_STEPS-2:0], trial_ge};
			rem_q  <= rem_nxt;
		end
		if (cmd.prep) begin
			xneg_q <= x[X_W-1];
			xmag_q <= x[X_W-1] ? X_W'(-x) : x;
		end
		if (cmd.mul_lo) begin
			pp0_q <= xmag_q[31:0] * cfg.steps_per_rev_q16;
		end
		if (cmd.mul_hi) begin
			pp1_q <= xmag_q[X_W-1:32] * cfg.steps_per_rev_q16;
		end
		if (cmd.scale) begin
			steps_q <= steps_nxt;
		end
		if (cmd.move) begin
			move_valid_q    <= 1'b1;
			target_pos_q    <= move_t;
			thread_active_q <= move_active;
		end else if (cmd.arm) begin
			move_valid_q    <= 1'b0;
			target_pos_q    <= '0;
			thread_active_q <= arm_l || arm_r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q      <= 1'b0;
			going_right_q <= 1'b0;
			turn_origin_q <= '0;
			pos_origin_q  <= '0;
		end else if (cmd.move) begin
			active_q <= move_active;
		end else if (cmd.arm && (arm_l || arm_r)) begin
			active_q      <= 1'b1;
			going_right_q <= !arm_l;
			turn_origin_q <= turns - 32'sd1;
			pos_origin_q  <= pos_q;
		end
	end

	assign armed         = active_q;
	assign move_valid    = move_valid_q;
	assign target_pos    = target_pos_q;
	assign thread_active = thread_active_q;

endmodule
`default_nettype wire

// ----- test/thread_target_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thread_target_checker - result checker for the threading leadscrew block
// Tracks register writes, predicts one result per input transfer with its own
// copy of the threading state, and compares each output transfer against the
// oldest prediction. Reports mismatch count and outstanding predictions.
// ----------------------------------------------------------------------------
module thread_target_checker
	import sstl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [31:0] spindle_count,
	input  logic signed [31:0] carriage_pos,
	input  logic               jog_switch_level,
	input  logic               left_button_level,
	input  logic               right_button_level,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               move_valid,
	input  logic signed [31:0] target_pos,
	input  logic               thread_active,
	output int                 fail_count,
	output int                 pending,
	output int                 checked,
	output int                 moves,
	output int                 arms
);

	localparam longint MAX32 = 64'sd2147483647;
	localparam longint MIN32 = -64'sd2147483648;
	localparam int PRODUCT_SHIFT = FRAC_BITS + 16;

	typedef struct packed {
		logic               move_valid;
		logic signed [31:0] target_pos;
		logic               thread_active;
	} move_t;

	sstl_cfg_t          regs;
	logic               armed;
	logic               heading_right;
	logic signed [31:0] turn_ref;
	logic signed [31:0] pos_ref;
	move_t              expected_moves[$];
	int                 errors;
	int                 n_checked;
	int                 n_moves;
	int                 n_arms;

	function automatic longint sat32(input longint v);
		if (v > MAX32) return MAX32;
		if (v < MIN32) return MIN32;
		return v;
	endfunction

	// Turn position times Q16.16 steps per turn, truncated toward zero.
	function automatic longint turns_to_steps(input longint x, input logic [31:0] spr);
		logic [63:0]  mag;
		logic [127:0] prod;
		logic [127:0] whole;
		mag = (x < 0) ? -x : x;
		prod = mag * spr;
		whole = prod >> PRODUCT_SHIFT;
		if (x < 0) begin
			if (whole > 128'd2147483648) return MIN32;
			return -longint'({32'd0, whole[31:0]});
		end
		if (whole > 128'd2147483647) return MAX32;
		return longint'({32'd0, whole[31:0]});
	endfunction

	// Advance the threading state by one item and return its result.
	function automatic move_t step_leadscrew(input logic signed [31:0] count,
			input logic signed [31:0] pos, input logic jog, input logic left_up,
			input logic right_up);
		longint ppr, turns, rem, frac, offs, x, steps, org, tgt, lim_l, lim_r;
		logic   arm_l, arm_r;
		move_t  r;
		r = '0;
		ppr = (regs.pulses_per_rev == 16'd0) ? 1 : longint'({48'd0, regs.pulses_per_rev});
		turns = longint'(count) / ppr;
		rem = longint'(count) % ppr;
		lim_l = longint'(regs.left_limit);
		lim_r = longint'(regs.right_limit);
		if (armed) begin
			frac = (rem * (longint'(1) << FRAC_BITS)) / ppr;
			offs = (longint'({48'd0, regs.start_offset_q16}) << FRAC_BITS) >>> 16;
			x = (turns - longint'(turn_ref)) * (longint'(1) << FRAC_BITS) + frac + offs;
			steps = turns_to_steps(x, regs.steps_per_rev_q16);
			org = longint'(pos_ref);
			if (heading_right) begin
				tgt = sat32(org - steps);
				if (tgt < org) tgt = org;
				if (jog) begin
					if (right_up) armed = 1'b0;
				end else if (tgt >= lim_r) begin
					armed = 1'b0;
					tgt = lim_r;
				end
			end else begin
				tgt = sat32(org + steps);
				if (tgt > org) tgt = org;
				if (jog) begin
					if (left_up) armed = 1'b0;
				end else if (tgt <= lim_l) begin
					armed = 1'b0;
					tgt = lim_l;
				end
			end
			if (jog && left_up && right_up) armed = 1'b0;
			r.move_valid = 1'b1;
			r.target_pos = tgt[31:0];
			n_moves++;
		end else begin
			arm_l = jog ? !left_up
				: (!left_up && regs.left_stop_enable && pos > regs.left_limit);
			arm_r = jog ? !right_up
				: (!right_up && regs.right_stop_enable && pos < regs.right_limit);
			if (arm_l || arm_r) begin
				heading_right = !arm_l;
				armed = 1'b1;
				turn_ref = 32'(turns - 1);
				pos_ref = pos;
				n_arms++;
			end
		end
		r.thread_active = armed;
		return r;
	endfunction

	task automatic flag_mismatch(input string field, input longint want, input longint got);
		errors++;
		$error("%s: expected %0d, got %0d", field, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		move_t want;
		move_t got;
		if (!arst_n) begin
			regs = '0;
			regs.pulses_per_rev = PPR_RESET;
			regs.steps_per_rev_q16 = SPR_RESET;
			armed = 1'b0;
			heading_right = 1'b0;
			turn_ref = '0;
			pos_ref = '0;
			expected_moves.delete();
			errors = 0;
			n_checked = 0;
			n_moves = 0;
			n_arms = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = '{move_valid, target_pos, thread_active};
				if (expected_moves.size() == 0) begin
					errors++;
					$error("result transfer with no item outstanding");
				end else begin
					want = expected_moves.pop_front();
					n_checked++;
					if (got.move_valid !== want.move_valid)
						flag_mismatch("move_valid", want.move_valid, got.move_valid);
					if (got.target_pos !== want.target_pos)
						flag_mismatch("target_pos", want.target_pos, got.target_pos);
					if (got.thread_active !== want.thread_active)
						flag_mismatch("thread_active", want.thread_active,
							got.thread_active);
				end
			end
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
				REG_PULSES_PER_REV:    regs.pulses_per_rev = cfg_data[15:0];
				REG_STEPS_PER_REV:     regs.steps_per_rev_q16 = cfg_data;
				REG_START_OFFSET:      regs.start_offset_q16 = cfg_data[15:0];
				REG_LEFT_LIMIT:        regs.left_limit = cfg_data;
				REG_RIGHT_LIMIT:       regs.right_limit = cfg_data;
				REG_LEFT_STOP_ENABLE:  regs.left_stop_enable = cfg_data[0];
				REG_RIGHT_STOP_ENABLE: regs.right_stop_enable = cfg_data[0];
				default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_moves.push_back(step_leadscrew(spindle_count, carriage_pos,
					jog_switch_level, left_button_level, right_button_level));
		end
		fail_count <= errors;
		pending <= expected_moves.size();
		checked <= n_checked;
		moves <= n_moves;
		arms <= n_arms;
	end

endmodule

// ----- test/tb_spindle_synced_thread_leadscrew_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spindle_synced_thread_leadscrew_top - threading leadscrew testbench
// Drives directed corner items and then randomized threading passes (arm,
// track the spindle, release or reach a stop) under several register
// settings, with random gaps and stalls on both channels and one long output
// hold-off. Checking is done by thread_target_checker beside the block.
// ----------------------------------------------------------------------------
module tb_spindle_synced_thread_leadscrew_top;
	import sstl_pkg::*;

	localparam int STUCK_LIMIT     = 4000;  // cycles without any transfer
	localparam int DRAIN_CYCLES    = 60;    // settle time after the last result
	localparam int PRESSURE_AT     = 300;   // result count that starts the hold-off
	localparam int PRESSURE_CYCLES = 600;
	localparam logic signed [31:0] MOST_NEG = 32'sh80000000;
	localparam logic signed [31:0] MOST_POS = 32'sh7fffffff;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [31:0] spindle_count = '0;
	logic signed [31:0] carriage_pos = '0;
	logic               jog_switch_level = 1'b1;
	logic               left_button_level = 1'b1;
	logic               right_button_level = 1'b1;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               move_valid;
	logic signed [31:0] target_pos;
	logic               thread_active;

	int fail_count;
	int pending;
	int checked;
	int moves;
	int arms;
	int sent = 0;
	int settings_loaded = 0;
	int stuck_cycles = 0;
	int cur_ppr = 2880;
	bit calm_in = 1'b0;

	spindle_synced_thread_leadscrew_top u_dut (.*);

	thread_target_checker u_checker (.*);

	always #10 clk = ~clk;

	// Watchdog: abort when neither channel nor the register port moves for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles == STUCK_LIMIT) begin
				$display("spindle_synced_thread_leadscrew_top verification failed");
				$finish;
			end
		end
	end

	// Offer one item after a random gap and hold it until the transfer.
	// Entered and left at a falling edge.
	task automatic send_sample(input logic signed [31:0] count, input logic signed [31:0] pos,
			input logic jog, input logic left_up, input logic right_up);
		int gap;
		// Every 40 items, maybe switch to a stretch of back-to-back offers.
		if (sent % 40 == 0) calm_in = ($urandom_range(0, 3) == 0);
		gap = calm_in ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		spindle_count <= count;
		carriage_pos <= pos;
		jog_switch_level <= jog;
		left_button_level <= left_up;
		right_button_level <= right_up;
		do @(posedge clk); while (in_stall);
		sent++;
		@(negedge clk);
	endtask

	// Drop valid, wait for every outstanding result, then let the pipeline settle.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
	endtask

	// Write all seven registers while the block is idle.
	task automatic load_settings(input logic [15:0] ppr, input logic [31:0] spr,
			input logic [15:0] offs, input logic signed [31:0] lim_l,
			input logic signed [31:0] lim_r, input logic en_l, input logic en_r);
		drain();
		write_reg(REG_PULSES_PER_REV, {16'd0, ppr});
		write_reg(REG_STEPS_PER_REV, spr);
		write_reg(REG_START_OFFSET, {16'd0, offs});
		write_reg(REG_LEFT_LIMIT, lim_l);
		write_reg(REG_RIGHT_LIMIT, lim_r);
		write_reg(REG_LEFT_STOP_ENABLE, {31'd0, en_l});
		write_reg(REG_RIGHT_STOP_ENABLE, {31'd0, en_r});
		cfg_we <= 1'b0;
		cur_ppr = (ppr == 16'd0) ? 1 : ppr;
		settings_loaded++;
	endtask

	// Result side: stall ahead of a result for a random number of cycles after it
	// shows up, with calm stretches, and once hold off long enough to back up the
	// block into its input.
	initial begin : receiver
		int  hold;
		int  taken;
		bit  calm;
		taken = 0;
		calm = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (taken % 40 == 0) calm = ($urandom_range(0, 3) == 0);
			hold = calm ? 0 : $urandom_range(0, 5);
			if (taken == PRESSURE_AT) hold = PRESSURE_CYCLES;
			if (hold > 0) begin
				out_stall <= 1'b1;
				do @(posedge clk); while (!out_valid);
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			taken++;
			@(negedge clk);
		end
	end

	initial begin : stimulus
		int                 quota;
		int                 stop_at;
		int                 stride;
		int                 advance;
		int                 ppr_pick;
		logic               jog;
		logic               go_left;
		logic               backward;
		logic               other;
		logic               lu;
		logic               ru;
		logic signed [31:0] count;
		logic signed [31:0] pos;

		// Hold reset, then release it between edges.
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed items at reset settings: 2880 pulses, 800 steps per turn,
		// stops disabled.
		send_sample(0, 0, 1'b1, 1'b1, 1'b1);            // idle, nothing pressed
		send_sample(0, 100, 1'b0, 1'b0, 1'b0);          // stop mode, stops disabled: no arm
		send_sample(5760, 100, 1'b1, 1'b0, 1'b0);       // both pressed: left wins
		send_sample(4320, 0, 1'b1, 1'b0, 1'b1);         // half a turn on: clamp at origin
		send_sample(-2880, 0, 1'b1, 1'b0, 1'b1);        // spindle backward: target moves
		send_sample(-4000, 0, 1'b1, 1'b1, 1'b1);        // both released: last target, disarm
		send_sample(0, -50, 1'b1, 1'b1, 1'b0);          // arm right
		send_sample(-6000, 0, 1'b1, 1'b1, 1'b0);        // right held
		send_sample(-7000, 0, 1'b1, 1'b1, 1'b1);        // release

		// Extremes: zero pulses per rev, widest steps and offset, stops at the rails.
		load_settings(16'd0, 32'hffffffff, 16'hffff, MOST_NEG, MOST_POS, 1'b1, 1'b1);
		send_sample(MOST_NEG, 0, 1'b1, 1'b0, 1'b1);     // turn origin wraps on arming
		send_sample(MOST_POS, 0, 1'b1, 1'b0, 1'b1);
		send_sample(MOST_NEG, 0, 1'b1, 1'b1, 1'b1);     // saturate negative, disarm
		send_sample(0, MOST_NEG, 1'b0, 1'b1, 1'b0);     // stop mode arm right
		send_sample(MOST_NEG, 0, 1'b0, 1'b1, 1'b0);
		send_sample(MOST_POS, MOST_POS, 1'b0, 1'b0, 1'b0); // buttons ignored while armed
		send_sample(0, 0, 1'b1, 1'b1, 1'b1);            // jog release disarms
		send_sample(0, MOST_POS, 1'b0, 1'b0, 1'b1);     // stop mode arm left
		send_sample(MOST_POS, MOST_NEG, 1'b0, 1'b1, 1'b1);
		send_sample(MOST_NEG, 0, 1'b1, 1'b1, 1'b1);

		// Near stops with a half-turn start offset: reach each stop and snap.
		load_settings(16'hffff, SPR_RESET, 16'h8000, -32'sd1000, 32'sd1000, 1'b1, 1'b1);
		send_sample(0, 0, 1'b0, 1'b0, 1'b1);            // arm left toward -1000
		send_sample(-196605, 0, 1'b0, 1'b1, 1'b1);      // passes the left stop
		send_sample(0, 0, 1'b0, 1'b1, 1'b0);            // arm right toward 1000
		send_sample(-196605, 0, 1'b0, 1'b1, 1'b1);      // passes the right stop
		send_sample(0, -2000, 1'b0, 1'b0, 1'b1);        // already past left stop: no arm
		send_sample(0, 5000, 1'b0, 1'b1, 1'b0);         // already past right stop: no arm

		// Random phases: two at the extremes, the rest with workable settings.
		for (int ph = 0; ph < 6; ph++) begin
			ppr_pick = (ph == 2) ? 2880
				: (ph % 2 == 1) ? $urandom_range(1, 65535) : $urandom_range(100, 5000);
			case (ph)
			0: load_settings(16'd1, 32'hffffffff, 16'hffff, MOST_NEG, MOST_POS, 1'b1, 1'b1);
			1: load_settings(16'hffff, 32'd0, 16'd0, MOST_POS, MOST_NEG, 1'b0, 1'b0);
			default: load_settings(16'(ppr_pick), $urandom_range(32'h0001_0000, 32'h0fa0_0000),
				16'($urandom_range(0, 65535)), -$urandom_range(0, 20000),
				$urandom_range(0, 20000), $urandom_range(0, 3) != 0,
				$urandom_range(0, 3) != 0);
			endcase
			quota = (ph < 2) ? 120 : 310;
			stop_at = sent + quota;
			while (sent < stop_at) begin
				if ($urandom_range(0, 4) == 0) begin
					// Noise: any levels, any count and position.
					send_sample($urandom, $urandom, 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				end else begin
					// One threading pass: press, follow the spindle, let go.
					jog = 1'($urandom_range(0, 1));
					go_left = 1'($urandom_range(0, 1));
					count = ($urandom_range(0, 7) == 0) ? $urandom
						: $urandom_range(0, 2097152) - 1048576;
					pos = ($urandom_range(0, 7) == 0) ? $urandom
						: $urandom_range(0, 50000) - 25000;
					send_sample(count, pos, jog, !go_left,
						go_left ? 1'($urandom_range(0, 1)) : 1'b0);
					// Mostly drive the spindle the way that moves the target.
					backward = ($urandom_range(0, 3) != 0);
					stride = 2 * cur_ppr;
					repeat ($urandom_range(1, 24)) begin
						advance = $urandom_range(0, stride);
						count = backward ? count - advance : count + advance;
						other = ($urandom_range(0, 5) != 0);
						if (!jog) {lu, ru} = 2'($urandom_range(0, 3));
						else if (go_left) {lu, ru} = {1'b0, other};
						else {lu, ru} = {other, 1'b0};
						send_sample(count, $urandom_range(0, 50000) - 25000, jog, lu, ru);
					end
					// Release the held button; a stop pass that never hit its stop
					// is cleared by a jog release.
					if (jog)
						send_sample(count, pos, 1'b1,
							go_left ? 1'b1 : 1'($urandom_range(0, 1)),
							go_left ? 1'($urandom_range(0, 1)) : 1'b1);
					else
						send_sample(count, pos, 1'b1, 1'b1, 1'b1);
				end
			end
		end

		drain();
		$display("covered %0d items under %0d register settings, %0d results checked",
			sent, settings_loaded, checked);
		$display("%0d targets issued over %0d armed passes, with one long output hold-off",
			moves, arms);
		if (fail_count == 0)
			$display("spindle_synced_thread_leadscrew_top verification clean");
		else
			$display("spindle_synced_thread_leadscrew_top verification failed");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/sstl_pkg.sv
rtl/sstl_cfg.sv
rtl/sstl_ctrl.sv
rtl/sstl_dp.sv
rtl/spindle_synced_thread_leadscrew_top.sv
test/thread_target_checker.sv
test/tb_spindle_synced_thread_leadscrew_top.sv
